// ----- sv/bupq_pkg.sv -----
// Shared types, constants and helpers for the bilinear 2x upscale quantiser.
`timescale 1ns / 1ps

package bupq_pkg;

    localparam int SAMPLE_W = 20;
    localparam int COL_W    = 11;
    localparam int ROW_W    = 12;
    localparam int PIX_W    = 16;
    localparam int SUM_W    = 23;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

    // Quad slots in emission order.
    localparam logic [1:0] QUAD_UP_LEFT  = 2'd0;
    localparam logic [1:0] QUAD_UP       = 2'd1;
    localparam logic [1:0] QUAD_LEFT     = 2'd2;
    localparam logic [1:0] QUAD_HERE     = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    typedef struct packed {
        logic [3:0]       mask;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        sample_t          pl;
        sample_t          top;
        sample_t          cl;
        sample_t          smp;
    } job_t;

    function automatic sum_t sx(input sample_t v);
        return {{(SUM_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
    endfunction

    // Round half up from 4 fractional bits, clamp to 0..65535.
    function automatic logic [PIX_W-1:0] quant16(input sum_t v);
        logic signed [SUM_W:0] t;
        t = {v[SUM_W-1], v} + (SUM_W+1)'(8);
        if (t[SUM_W]) begin
            return '0;
        end else if (|t[SUM_W-1:PIX_W+4]) begin
            return '1;
        end else begin
            return t[PIX_W+3:4];
        end
    endfunction

endpackage

// ----- sv/bilinear_upscale2x_quantise_unit.sv -----
// Top level of the bilinear 2x upscaler with 16-bit quantization.
// Source samples enter on the s_ stream in raster order, one per beat; each
// source pixel leaves on the m_ stream as one 2x2 quad beat. A quad goes out
// once its right and lower neighbors have arrived, so one input beat causes
// zero to four output beats; m_tlast marks the last of them, m_tuser marks the
// final quad of the frame. source_width and source_height are written through
// cfg_we/cfg_index/cfg_wdata while the stream is idle; a write restarts the frame.
// Input beats are taken one per cycle as long as the job queue has room; output
// runs at one quad per cycle while m_tready is high, so sustained input rate is
// one beat per cycle on rows that emit one quad per sample (the last row emits
// two, last column more). On its way to the output register, the first quad of
// an input beat passes through the line buffer read stage, the queue and the
// job register, in that order.
// Reset clears position counters, the queue and the output valid flag, and sets
// the frame to 1024 x 768; the line buffer is not cleared. When m_tready is low
// the output beat holds, the queue fills and then s_tready drops.
`timescale 1ns / 1ps

module bilinear_upscale2x_quantise_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [bupq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bupq_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // sample[19:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [87:0]                     m_tdata,   // quad_col, quad_row, pix_even_even,
                                                       // pix_odd_even, pix_even_odd, pix_odd_odd
    output logic                            m_tlast,   // last_of_run
    output logic                            m_tuser    // frame_end
);

    logic           push_valid;
    logic           push_ready;
    bupq_pkg::job_t push_job;
    logic           pop_valid;
    logic           pop_ready;
    bupq_pkg::job_t pop_job;

    bupq_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  (bupq_pkg::sample_t'(s_tdata[19:0])),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    bupq_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    bupq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (pop_valid),
        .job_pop   (pop_ready),
        .job_in    (pop_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- sv/bupq_front.sv -----
// Front end: sample intake, position tracking, line buffer and quad classification.
`timescale 1ns / 1ps

module bupq_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [bupq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bupq_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  bupq_pkg::sample_t                  in_sample,
    output logic                               push_valid,
    input  logic                               push_ready,
    output bupq_pkg::job_t                     push_job
);

    localparam int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int W_RST = (1024 > MAX_WIDTH)  ? MAX_WIDTH  : 1024;
    localparam int H_RST = (768  > MAX_HEIGHT) ? MAX_HEIGHT : 768;

    logic [XW-1:0] wlast_reg, wlast_next;
    logic [YW-1:0] hlast_reg, hlast_next;
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;

    logic [bupq_pkg::SAMPLE_W-1:0] line_mem [MAX_WIDTH];
    logic [bupq_pkg::SAMPLE_W-1:0] rd_reg;

    logic                 st_valid_reg, st_valid_next;
    bupq_pkg::sample_t    st_smp_reg;
    logic [XW-1:0]        st_x_reg;
    logic [YW-1:0]        st_y_reg;
    logic                 st_lastc_reg;
    logic                 st_lastr_reg;
    bupq_pkg::sample_t    pl_reg, pl_next;
    bupq_pkg::sample_t    cl_reg, cl_next;

    logic [11:0]          wv;
    logic [12:0]          hv;
    logic                 accept;
    logic                 advance;
    logic                 st_up;
    logic                 st_left;
    bupq_pkg::sample_t    top;
    logic [3:0]           mask;

    assign wv = cfg_wdata[11:0];
    assign hv = cfg_wdata[12:0];

    assign st_up   = (st_y_reg != '0);
    assign st_left = (st_x_reg != '0);
    assign top     = st_up ? bupq_pkg::sample_t'(rd_reg) : st_smp_reg;
    assign mask    = {st_lastr_reg & st_lastc_reg, st_lastr_reg & st_left,
                      st_up & st_lastc_reg, st_up & st_left};

    assign advance    = st_valid_reg & ((mask == 4'd0) | push_ready);
    assign push_valid = st_valid_reg & (mask != 4'd0);
    assign in_ready   = ~st_valid_reg | advance;
    assign accept     = in_valid & in_ready;

    always_comb begin
        push_job.mask = mask;
        push_job.col  = bupq_pkg::COL_W'(st_x_reg);
        push_job.row  = bupq_pkg::ROW_W'(st_y_reg);
        push_job.pl   = pl_reg;
        push_job.top  = top;
        push_job.cl   = cl_reg;
        push_job.smp  = st_smp_reg;
    end

    always_comb begin
        wlast_next    = wlast_reg;
        hlast_next    = hlast_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        st_valid_next = st_valid_reg;
        pl_next       = pl_reg;
        cl_next       = cl_reg;
        if (advance) begin
            st_valid_next = 1'b0;
            pl_next       = top;
            cl_next       = st_smp_reg;
        end
        if (accept) begin
            st_valid_next = 1'b1;
            if (x_reg == wlast_reg) begin
                x_next = '0;
                y_next = (y_reg == hlast_reg) ? '0 : y_reg + YW'(1);
            end else begin
                x_next = x_reg + XW'(1);
            end
        end
        if (cfg_we) begin
            case (cfg_index)
                bupq_pkg::REG_SOURCE_WIDTH: begin
                    if (wv == 12'd0) begin
                        wlast_next = '0;
                    end else if (32'(wv) > MAX_WIDTH) begin
                        wlast_next = XW'(MAX_WIDTH - 1);
                    end else begin
                        wlast_next = XW'(wv - 12'd1);
                    end
                    x_next = '0;
                    y_next = '0;
                end
                bupq_pkg::REG_SOURCE_HEIGHT: begin
                    if (hv == 13'd0) begin
                        hlast_next = '0;
                    end else if (32'(hv) > MAX_HEIGHT) begin
                        hlast_next = YW'(MAX_HEIGHT - 1);
                    end else begin
                        hlast_next = YW'(hv - 13'd1);
                    end
                    x_next = '0;
                    y_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlast_reg    <= XW'(W_RST - 1);
            hlast_reg    <= YW'(H_RST - 1);
            x_reg        <= '0;
            y_reg        <= '0;
            st_valid_reg <= 1'b0;
            pl_reg       <= '0;
            cl_reg       <= '0;
        end else begin
            wlast_reg    <= wlast_next;
            hlast_reg    <= hlast_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            st_valid_reg <= st_valid_next;
            pl_reg       <= pl_next;
            cl_reg       <= cl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_smp_reg   <= in_sample;
            st_x_reg     <= x_reg;
            st_y_reg     <= y_reg;
            st_lastc_reg <= (x_reg == wlast_reg);
            st_lastr_reg <= (y_reg == hlast_reg);
        end
    end

    // Read-first line buffer: the old entry is the sample above.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg          <= line_mem[x_reg];
            line_mem[x_reg] <= in_sample;
        end
    end

endmodule

// ----- sv/bupq_queue.sv -----
// Short job queue between the front end and the quad generator.
`timescale 1ns / 1ps

module bupq_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  bupq_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output bupq_pkg::job_t pop_job
);

    bupq_pkg::job_t                  slot_reg [bupq_pkg::QDEPTH];
    logic [bupq_pkg::QPTR_W-1:0]     wr_reg, wr_next;
    logic [bupq_pkg::QPTR_W-1:0]     rd_reg, rd_next;
    logic [bupq_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = (cnt_reg != bupq_pkg::QCNT_W'(bupq_pkg::QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_job    = slot_reg[rd_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb begin
        wr_next  = do_push ? wr_reg + bupq_pkg::QPTR_W'(1) : wr_reg;
        rd_next  = do_pop  ? rd_reg + bupq_pkg::QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + bupq_pkg::QCNT_W'(1);
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - bupq_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_reg] <= push_job;
        end
    end

endmodule

// ----- sv/bupq_back.sv -----
// Back end: walks each job's quads, averages, quantizes and registers the output beat.
`timescale 1ns / 1ps

module bupq_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         job_valid,
    output logic                         job_pop,
    input  bupq_pkg::job_t               job_in,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [87:0]                  m_tdata,
    output logic                         m_tlast,
    output logic                         m_tuser
);

    bupq_pkg::job_t              job_reg;
    logic [3:0]                  rem_reg, rem_next;
    logic                        mv_reg, mv_next;
    logic [bupq_pkg::COL_W-1:0]  col_reg;
    logic [bupq_pkg::ROW_W-1:0]  row_reg;
    logic [bupq_pkg::PIX_W-1:0]  ee_reg, oe_reg, eo_reg, oo_reg;
    logic                        last_reg;
    logic                        fend_reg;

    logic                        load;
    logic                        emit;
    logic [1:0]                  k;
    logic [3:0]                  rem_after;
    bupq_pkg::sample_t           a, b, c, d;
    logic [bupq_pkg::COL_W-1:0]  qcol;
    logic [bupq_pkg::ROW_W-1:0]  qrow;

    assign load = ~mv_reg | m_tready;
    assign emit = load & (rem_reg != 4'd0);

    always_comb begin
        if (rem_reg[0]) begin
            k = bupq_pkg::QUAD_UP_LEFT;
        end else if (rem_reg[1]) begin
            k = bupq_pkg::QUAD_UP;
        end else if (rem_reg[2]) begin
            k = bupq_pkg::QUAD_LEFT;
        end else begin
            k = bupq_pkg::QUAD_HERE;
        end
        rem_after    = rem_reg;
        rem_after[k] = 1'b0;
    end

    always_comb begin
        case (k)
            bupq_pkg::QUAD_UP_LEFT: begin
                a = job_reg.pl;  b = job_reg.top; c = job_reg.cl;  d = job_reg.smp;
                qcol = job_reg.col - bupq_pkg::COL_W'(1);
                qrow = job_reg.row - bupq_pkg::ROW_W'(1);
            end
            bupq_pkg::QUAD_UP: begin
                a = job_reg.top; b = job_reg.top; c = job_reg.smp; d = job_reg.smp;
                qcol = job_reg.col;
                qrow = job_reg.row - bupq_pkg::ROW_W'(1);
            end
            bupq_pkg::QUAD_LEFT: begin
                a = job_reg.cl;  b = job_reg.smp; c = job_reg.cl;  d = job_reg.smp;
                qcol = job_reg.col - bupq_pkg::COL_W'(1);
                qrow = job_reg.row;
            end
            default: begin
                a = job_reg.smp; b = job_reg.smp; c = job_reg.smp; d = job_reg.smp;
                qcol = job_reg.col;
                qrow = job_reg.row;
            end
        endcase
    end

    always_comb begin
        job_pop  = job_valid & ((rem_reg == 4'd0) | (emit & (rem_after == 4'd0)));
        rem_next = emit ? rem_after : rem_reg;
        if (job_pop) begin
            rem_next = job_in.mask;
        end
        mv_next = load ? (rem_reg != 4'd0) : mv_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            mv_reg  <= 1'b0;
        end else begin
            rem_reg <= rem_next;
            mv_reg  <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            job_reg <= job_in;
        end
        if (emit) begin
            col_reg  <= qcol;
            row_reg  <= qrow;
            ee_reg   <= bupq_pkg::quant16(bupq_pkg::sx(a) <<< 2);
            oe_reg   <= bupq_pkg::quant16((bupq_pkg::sx(a) + bupq_pkg::sx(b)) <<< 1);
            eo_reg   <= bupq_pkg::quant16((bupq_pkg::sx(a) + bupq_pkg::sx(c)) <<< 1);
            oo_reg   <= bupq_pkg::quant16(bupq_pkg::sx(a) + bupq_pkg::sx(b)
                                          + bupq_pkg::sx(c) + bupq_pkg::sx(d));
            last_reg <= (rem_after == 4'd0);
            fend_reg <= (k == bupq_pkg::QUAD_HERE);
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {1'b0, oo_reg, eo_reg, oe_reg, ee_reg, row_reg, col_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = fend_reg;

endmodule
